/* rtl/srlw_pkg.sv */
`default_nettype none

package srlw_pkg;

  localparam int unsigned LINE_BYTES_DEF = 16;

  // input word kinds (in_tuser)
  localparam logic [1:0] KIND_PUT    = 2'd0;
  localparam logic [1:0] KIND_FINISH = 2'd1;
  localparam logic [1:0] KIND_START  = 2'd2;

  localparam int unsigned HDR_LEN = 21;
  localparam int unsigned END_LEN = 11;

  localparam logic [7:0] CHR_S  = 8'h53;
  localparam logic [7:0] CHR_1  = 8'h31;
  localparam logic [7:0] CHR_NL = 8'h0A;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    hex_char = (nib < 4'd10) ? (8'h30 + {4'h0, nib}) : (8'h37 + {4'h0, nib});
  endfunction

  // "S00800004" "64C41534889\n"
  function automatic logic [7:0] hdr_char(input logic [4:0] idx);
    case (idx)
      5'd0:    hdr_char = "S";
      5'd1:    hdr_char = "0";
      5'd2:    hdr_char = "0";
      5'd3:    hdr_char = "8";
      5'd4:    hdr_char = "0";
      5'd5:    hdr_char = "0";
      5'd6:    hdr_char = "0";
      5'd7:    hdr_char = "0";
      5'd8:    hdr_char = "4";
      5'd9:    hdr_char = "6";
      5'd10:   hdr_char = "4";
      5'd11:   hdr_char = "C";
      5'd12:   hdr_char = "4";
      5'd13:   hdr_char = "1";
      5'd14:   hdr_char = "5";
      5'd15:   hdr_char = "3";
      5'd16:   hdr_char = "4";
      5'd17:   hdr_char = "8";
      5'd18:   hdr_char = "8";
      5'd19:   hdr_char = "9";
      5'd20:   hdr_char = CHR_NL;
      default: hdr_char = CHR_NL;
    endcase
  endfunction

  // "S9030000FC\n"
  function automatic logic [7:0] end_char(input logic [4:0] idx);
    case (idx)
      5'd0:    end_char = "S";
      5'd1:    end_char = "9";
      5'd2:    end_char = "0";
      5'd3:    end_char = "3";
      5'd4:    end_char = "0";
      5'd5:    end_char = "0";
      5'd6:    end_char = "0";
      5'd7:    end_char = "0";
      5'd8:    end_char = "F";
      5'd9:    end_char = "C";
      5'd10:   end_char = CHR_NL;
      default: end_char = CHR_NL;
    endcase
  endfunction

endpackage

`default_nettype wire

/* rtl/srlw_buf.sv */
`default_nettype none

// Line buffer: one write port, one read port with registered data.
module srlw_buf #(
  parameter int unsigned LINE_BYTES = 16,
  parameter int unsigned IDX_W      = 4
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [IDX_W-1:0] wr_addr,
  input  wire logic [7:0]       wr_data,
  input  wire logic [IDX_W-1:0] rd_addr,
  output logic      [7:0]       rd_data
);

  logic [7:0] mem [LINE_BYTES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

/* rtl/srecord_line_writer.sv */
`default_nettype none

// S19 text writer.
// Input channel (in_*): one word per command. in_tuser carries the kind
// (put byte, finish, start); in_tdata carries the data byte and its address.
// A put stores the byte into the line buffer; the word that fills the
// buffer starts an S1 line. Finish writes out any partial line as S1, then
// the fixed S9 line. Start empties the buffer and writes the S0 header.
// Output channel (out_*): one ASCII character per word; out_tlast marks the
// final character caused by one input word.
// Timing: a word that starts output loads the sequencer state, from which
// the first character is registered; then one character per cycle while
// out_tready is high. An S1 line of n bytes is 11 + 2n characters (43 for
// a full 16-byte line), S0 is 21, S9 is 11. in_tready is low while a line
// is being written, so a put that fills the buffer holds off the next word
// until its line is written. Data bytes are fetched from the buffer RAM
// ahead of use. A stall on out_tready freezes the sequencer; nothing is lost.
// Reset (rst_n low, synchronous) empties the buffer and idles the block.
module srecord_line_writer
  import srlw_pkg::*;
#(
  parameter int unsigned LINE_BYTES = LINE_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // [7:0] data, [23:8] address
  input  wire logic [1:0]  in_tuser,   // [1:0] kind
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [7:0]  out_tdata,  // [7:0] out_char
  output logic             out_tlast   // last
);

  localparam int unsigned IDX_W = (LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 1;
  localparam int unsigned FC_W  = $clog2(LINE_BYTES + 1);
  localparam int unsigned BI_W  = $clog2(LINE_BYTES + 4);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_FIX  = 7'b0000010,
    ST_LS   = 7'b0000100,
    ST_L1   = 7'b0001000,
    ST_LHI  = 7'b0010000,
    ST_LLO  = 7'b0100000,
    ST_LNL  = 7'b1000000
  } state_t;

  state_t           state_r, state_nxt;
  logic [FC_W-1:0]  fill_r, fill_nxt;
  logic [FC_W-1:0]  cnt_r, cnt_nxt;
  logic [15:0]      addr_r, addr_nxt;
  logic [BI_W-1:0]  bi_r, bi_nxt;
  logic [IDX_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [7:0]       cur_r, cur_nxt;
  logic [7:0]       sum_r, sum_nxt;
  logic [4:0]       fx_r, fx_nxt;
  logic             hdr_sel_r, hdr_sel_nxt;
  logic             then_end_r, then_end_nxt;
  logic             ov_r, ov_nxt;
  logic [7:0]       och_r, och_nxt;
  logic             olast_r, olast_nxt;

  logic [1:0]       kind;
  logic [7:0]       in_data;
  logic [15:0]      in_addr;
  logic             acc;
  logic             adv;
  logic             wr_en;
  logic [7:0]       rd_q;
  logic [FC_W-1:0]  fill_inc;
  logic [7:0]       fix_ch;
  logic             fix_end;
  logic [7:0]       next_byte;
  logic             next_is_sum;

  assign kind    = in_tuser;
  assign in_data = in_tdata[7:0];
  assign in_addr = in_tdata[23:8];

  assign in_tready = (state_r == ST_IDLE);
  assign acc       = in_tvalid && in_tready;
  assign adv       = (state_r != ST_IDLE) && (!ov_r || out_tready);
  assign wr_en     = acc && (kind == KIND_PUT);
  assign fill_inc  = fill_r + FC_W'(1);

  srlw_buf #(
    .LINE_BYTES (LINE_BYTES),
    .IDX_W      (IDX_W)
  ) u_buf (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (fill_r[IDX_W-1:0]),
    .wr_data (in_data),
    .rd_addr (rd_idx_r),
    .rd_data (rd_q)
  );

  assign fix_ch  = hdr_sel_r ? hdr_char(fx_r) : end_char(fx_r);
  assign fix_end = hdr_sel_r ? (fx_r == 5'(HDR_LEN - 1)) : (fx_r == 5'(END_LEN - 1));

  // byte following bi_r: address high, address low, data..., checksum
  always_comb begin
    next_is_sum = (bi_r == BI_W'(cnt_r) + BI_W'(2));
    if (bi_r == BI_W'(0)) begin
      next_byte = addr_r[15:8];
    end else if (bi_r == BI_W'(1)) begin
      next_byte = addr_r[7:0];
    end else if (next_is_sum) begin
      next_byte = ~sum_r;
    end else begin
      next_byte = rd_q;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    fill_nxt     = fill_r;
    cnt_nxt      = cnt_r;
    addr_nxt     = addr_r;
    bi_nxt       = bi_r;
    rd_idx_nxt   = rd_idx_r;
    cur_nxt      = cur_r;
    sum_nxt      = sum_r;
    fx_nxt       = fx_r;
    hdr_sel_nxt  = hdr_sel_r;
    then_end_nxt = then_end_r;
    ov_nxt       = ov_r && !out_tready;
    och_nxt      = och_r;
    olast_nxt    = olast_r;

    if (acc) begin
      case (kind)
        KIND_PUT: begin
          if (fill_r == '0) begin
            addr_nxt = in_addr;
          end
          if (fill_inc == FC_W'(LINE_BYTES)) begin
            fill_nxt     = '0;
            cnt_nxt      = fill_inc;
            then_end_nxt = 1'b0;
            state_nxt    = ST_LS;
            cur_nxt      = 8'(fill_inc) + 8'd3;
            sum_nxt      = 8'(fill_inc) + 8'd3;
            bi_nxt       = '0;
            rd_idx_nxt   = '0;
          end else begin
            fill_nxt = fill_inc;
          end
        end
        KIND_FINISH: begin
          fx_nxt      = '0;
          hdr_sel_nxt = 1'b0;
          if (fill_r != '0) begin
            fill_nxt     = '0;
            cnt_nxt      = fill_r;
            then_end_nxt = 1'b1;
            state_nxt    = ST_LS;
            cur_nxt      = 8'(fill_r) + 8'd3;
            sum_nxt      = 8'(fill_r) + 8'd3;
            bi_nxt       = '0;
            rd_idx_nxt   = '0;
          end else begin
            state_nxt = ST_FIX;
          end
        end
        KIND_START: begin
          fill_nxt    = '0;
          fx_nxt      = '0;
          hdr_sel_nxt = 1'b1;
          state_nxt   = ST_FIX;
        end
        default: begin
        end
      endcase
    end

    if (adv) begin
      ov_nxt    = 1'b1;
      olast_nxt = 1'b0;
      case (state_r)
        ST_FIX: begin
          och_nxt   = fix_ch;
          olast_nxt = fix_end;
          if (fix_end) begin
            state_nxt = ST_IDLE;
          end else begin
            fx_nxt = fx_r + 5'd1;
          end
        end
        ST_LS: begin
          och_nxt   = CHR_S;
          state_nxt = ST_L1;
        end
        ST_L1: begin
          och_nxt   = CHR_1;
          state_nxt = ST_LHI;
        end
        ST_LHI: begin
          och_nxt   = hex_char(cur_r[7:4]);
          state_nxt = ST_LLO;
        end
        ST_LLO: begin
          och_nxt = hex_char(cur_r[3:0]);
          if (bi_r == BI_W'(cnt_r) + BI_W'(3)) begin
            state_nxt = ST_LNL;
          end else begin
            cur_nxt   = next_byte;
            bi_nxt    = bi_r + BI_W'(1);
            state_nxt = ST_LHI;
            if (!next_is_sum) begin
              sum_nxt = sum_r + next_byte;
            end
            // data bytes advance the prefetch pointer
            if (bi_r > BI_W'(1) && !next_is_sum) begin
              rd_idx_nxt = rd_idx_r + IDX_W'(1);
            end
          end
        end
        ST_LNL: begin
          och_nxt   = CHR_NL;
          olast_nxt = !then_end_r;
          if (then_end_r) begin
            fx_nxt      = '0;
            hdr_sel_nxt = 1'b0;
            state_nxt   = ST_FIX;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
        default: begin
          state_nxt = ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      fill_r  <= '0;
      addr_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      addr_r  <= addr_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r      <= cnt_nxt;
    bi_r       <= bi_nxt;
    rd_idx_r   <= rd_idx_nxt;
    cur_r      <= cur_nxt;
    sum_r      <= sum_nxt;
    fx_r       <= fx_nxt;
    hdr_sel_r  <= hdr_sel_nxt;
    then_end_r <= then_end_nxt;
    och_r      <= och_nxt;
    olast_r    <= olast_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = och_r;
  assign out_tlast  = olast_r;

endmodule

`default_nettype wire
